@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// Implication checks, same cycle and next cycle, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ sv/corot_pkg.sv @@
// ----------------------------------------------------------------------------
// corot_pkg: shared types and constants
// Field widths, codes, the sequencer state type and table controls of the reservation table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package corot_pkg;

  // word field widths
  localparam int SECTOR_W     = 40;
  localparam int COUNT_W      = 21;
  localparam int SLOT_W       = 4;
  localparam int LOG2_W       = 3;
  localparam int SECTOR_SHIFT = 9;
  // byte address plus length needs one bit more than the shifted sector
  localparam int ADDR_W       = SECTOR_W + SECTOR_SHIFT + 1;
  localparam int SHIFT_W      = 5;

  // request mode codes
  localparam logic MODE_RESERVE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // configuration register indexes
  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_LOG2   = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // entry table controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } mem_ctl_t;

endpackage

@@ sv/corot_span.sv @@
// ----------------------------------------------------------------------------
// corot_span: cluster span calculator
// Turns a sector and byte count into registered first and last cluster numbers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module corot_span import corot_pkg::*; #(
  parameter int PAGE_BYTES_LOG2 = 12,
  parameter int CL_W            = 38
) (
  input  logic                clk,
  input  logic                load,
  input  logic [SECTOR_W-1:0] start_sector,
  input  logic [COUNT_W-1:0]  byte_count,
  input  logic [LOG2_W-1:0]   pages_log2,
  output logic [CL_W-1:0]     first,
  output logic [CL_W-1:0]     last
);

  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  addr_end;
  logic [COUNT_W-1:0] len_m1;
  logic [SHIFT_W-1:0] sh;

  // byte range of the request, zero length counts as one byte
  always_comb begin
    addr     = ADDR_W'({start_sector, {SECTOR_SHIFT{1'b0}}});
    len_m1   = (byte_count == '0) ? '0 : byte_count - COUNT_W'(1);
    addr_end = addr + ADDR_W'(len_m1);
    sh       = SHIFT_W'(PAGE_BYTES_LOG2) + SHIFT_W'(pages_log2);
  end

  // cluster numbers
  always_ff @(posedge clk) begin
    if (load) begin
      first <= CL_W'(addr >> sh);
      last  <= CL_W'(addr_end >> sh);
    end
  end

endmodule

@@ sv/corot_cmp.sv @@
// ----------------------------------------------------------------------------
// corot_cmp: span conflict comparator
// Shared unit that checks one stored entry against the pending request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module corot_cmp import corot_pkg::*; #(
  parameter int CL_W = 38
) (
  input  logic            ent_valid,
  input  logic [CL_W-1:0] ent_first,
  input  logic [CL_W-1:0] ent_last,
  input  logic            ent_wr,
  input  logic [CL_W-1:0] req_first,
  input  logic [CL_W-1:0] req_last,
  input  logic            req_wr,
  output logic            conflict
);

  // spans meet and at least one side writes
  assign conflict = ent_valid && (ent_first <= req_last) && (req_first <= ent_last) &&
                    (req_wr || ent_wr);

endmodule

@@ sv/corot_mem.sv @@
// ----------------------------------------------------------------------------
// corot_mem: entry table
// Span memory with one write and one registered read port, plus valid flops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module corot_mem import corot_pkg::*; #(
  parameter int MAX_SLOTS = 16,
  parameter int CL_W      = 38,
  parameter int IDX_W     = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  mem_ctl_t         ctl,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [CL_W-1:0]  wr_first,
  input  logic [CL_W-1:0]  wr_last,
  input  logic             wr_wr,
  input  logic [IDX_W-1:0] rd_addr,
  output logic             rd_valid,
  output logic [CL_W-1:0]  rd_first,
  output logic [CL_W-1:0]  rd_last,
  output logic             rd_wr
);

  localparam int DATA_W = 2 * CL_W + 1;

  logic [DATA_W-1:0]    mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] valid;
  logic [DATA_W-1:0]    rd_data;

  // span storage
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {wr_first, wr_last, wr_wr};
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end else if (ctl.clr_en) begin
        valid[wr_addr] <= 1'b0;
      end
      if (ctl.rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_first = rd_data[DATA_W-1 -: CL_W];
  assign rd_last  = rd_data[CL_W:1];
  assign rd_wr    = rd_data[0];

endmodule

@@ sv/cluster_overlap_reservation_table_top.sv @@
// ----------------------------------------------------------------------------
// cluster_overlap_reservation_table_top: address range lock table
// Grants or refuses block request reservations by cluster span overlap.
// ----------------------------------------------------------------------------
// reserve: accept, a scan of every entry (ends early on a hit), then a done state
// release, bypass or bad slot: accept, then a done state with no scan
// scan length is set by the single read port of the entry memory
// one word in flight; the next is taken while the result waits at the output
// synchronous reset clears valid bits, config to enabled and 64-page clusters
`timescale 1ns / 1ps

module cluster_overlap_reservation_table_top import corot_pkg::*; #(
  parameter int MAX_SLOTS       = 16,
  parameter int PAGE_BYTES_LOG2 = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [SECTOR_W-1:0] start_sector,
  input  logic [COUNT_W-1:0]  byte_count,
  input  logic                is_write,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                granted,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [LOG2_W-1:0]   cfg_data
);

  `include "assert_macros.svh"

  localparam int CL_W  = ADDR_W - PAGE_BYTES_LOG2;
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  state_t              state, state_next;
  logic                enabled;
  logic [LOG2_W-1:0]   pages_log2;
  logic [IDX_W-1:0]    req_slot;
  logic                req_wr;
  logic [IDX_W-1:0]    scan_idx;
  logic                issue_done;
  logic                rd_live;
  logic                rd_last;
  logic                res_granted;

  logic                accept;
  logic                slot_ok;
  logic                bypass;
  logic                to_scan;
  logic                span_load;
  logic                finish;
  logic                hit;
  logic                out_free;
  mem_ctl_t            mctl;
  logic [IDX_W-1:0]    mem_addr;
  logic [CL_W-1:0]     req_first, req_last;
  logic                ent_valid, ent_wr;
  logic [CL_W-1:0]     ent_first, ent_last;

  // span unit
  corot_span #(
    .PAGE_BYTES_LOG2(PAGE_BYTES_LOG2),
    .CL_W           (CL_W)
  ) u_span (
    .clk         (clk),
    .load        (span_load),
    .start_sector(start_sector),
    .byte_count  (byte_count),
    .pages_log2  (pages_log2),
    .first       (req_first),
    .last        (req_last)
  );

  // entry table
  corot_mem #(
    .MAX_SLOTS(MAX_SLOTS),
    .CL_W     (CL_W),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mctl),
    .wr_addr (mem_addr),
    .wr_first(req_first),
    .wr_last (req_last),
    .wr_wr   (req_wr),
    .rd_addr (scan_idx),
    .rd_valid(ent_valid),
    .rd_first(ent_first),
    .rd_last (ent_last),
    .rd_wr   (ent_wr)
  );

  // shared comparator
  corot_cmp #(
    .CL_W(CL_W)
  ) u_cmp (
    .ent_valid(ent_valid),
    .ent_first(ent_first),
    .ent_last (ent_last),
    .ent_wr   (ent_wr),
    .req_first(req_first),
    .req_last (req_last),
    .req_wr   (req_wr),
    .conflict (hit)
  );

  // word decode at the input
  assign accept   = in_valid && !in_stall;
  assign slot_ok  = 32'(slot) < MAX_SLOTS;
  assign bypass   = !enabled || (mode == MODE_RELEASE);
  assign to_scan  = !bypass && slot_ok;
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == S_SCAN) && rd_live && (hit || rd_last);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = to_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall    = 1'b1;
    span_load   = 1'b0;
    mctl        = '0;
    mem_addr    = req_slot;
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        span_load   = accept;
        mem_addr    = IDX_W'(slot);
        mctl.clr_en = accept && enabled && (mode == MODE_RELEASE) && slot_ok;
      end
      S_SCAN: begin
        mctl.rd_en  = !issue_done;
        mctl.wr_en  = finish && !hit;
      end
      S_DONE: begin
        in_stall    = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      enabled    <= 1'b1;
      pages_log2 <= LOG2_W'(6);
      issue_done <= 1'b0;
      rd_live    <= 1'b0;
      rd_last    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_live <= mctl.rd_en;
      rd_last <= mctl.rd_en && (scan_idx == IDX_W'(MAX_SLOTS - 1));
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ENABLE: enabled    <= cfg_data[0];
          CFG_LOG2:   pages_log2 <= cfg_data;
          default:    enabled    <= enabled;
        endcase
      end
      if (accept) begin
        issue_done <= 1'b0;
      end else if (mctl.rd_en && (scan_idx == IDX_W'(MAX_SLOTS - 1))) begin
        issue_done <= 1'b1;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_slot    <= IDX_W'(slot);
      req_wr      <= is_write;
      scan_idx    <= '0;
      res_granted <= !(enabled && (mode == MODE_RESERVE) && !slot_ok);
    end else begin
      if (mctl.rd_en) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (finish) begin
        res_granted <= !hit;
      end
    end
    if (state == S_DONE && out_free) begin
      granted <= res_granted;
    end
  end

  // checks
  `ASSERT_NEXT(a_reserve_scans, clk, rst, accept && to_scan, state == S_SCAN)
  `ASSERT_NEXT(a_bypass_done, clk, rst, accept && !to_scan, state == S_DONE)
  `ASSERT_SAME(a_read_in_scan, clk, rst, rd_live, $past(state) == S_SCAN)
  `ASSERT_NEXT(a_hit_refuses, clk, rst, finish && hit, !res_granted)

endmodule
